[rtl/core/xdp_pkg.sv]
// Shared types, character codes and constants of the duration parser.
package xdp_pkg;

  localparam int MAX_DIGITS_DEF      = 6;
  localparam int FRACTION_DIGITS_DEF = 6;
  localparam int TICK_DIGITS         = 6;
  localparam int QUEUE_DEPTH         = 2;
  localparam int TICKS_W             = 64;
  localparam int MULT_B_W            = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  localparam logic [MULT_B_W-1:0] TICKS_PER_HOUR = 32'd3600000000;
  localparam logic [MULT_B_W-1:0] TICKS_PER_MIN  = 32'd60000000;
  localparam logic [MULT_B_W-1:0] TICKS_PER_SEC  = 32'd1000000;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_AFTER_P = 4'd1,
    PH_DAY_INT = 4'd2,
    PH_AFTER_D = 4'd3,
    PH_H_WAIT  = 4'd4,
    PH_H_INT   = 4'd5,
    PH_M_WAIT  = 4'd6,
    PH_M_INT   = 4'd7,
    PH_S_WAIT  = 4'd8,
    PH_S_INT   = 4'd9,
    PH_T_FRAC1 = 4'd10,
    PH_T_FRAC  = 4'd11,
    PH_DONE    = 4'd12,
    PH_B_INT   = 4'd13,
    PH_B_FRAC1 = 4'd14,
    PH_B_FRAC  = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_SIGN = 2'd2,
    BK_OUT  = 2'd3
  } bk_state_t;

  // Scale of a fraction with n kept digits to microseconds: 10^(6-n).
  function automatic logic [MULT_B_W-1:0] frac_scale(input logic [2:0] n);
    logic [MULT_B_W-1:0] s;
    case (n)
      3'd0: s = 32'd1000000;
      3'd1: s = 32'd100000;
      3'd2: s = 32'd10000;
      3'd3: s = 32'd1000;
      3'd4: s = 32'd100;
      3'd5: s = 32'd10;
      3'd6: s = 32'd1;
      default: s = 32'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/xdp_if.sv]
// Request channel interfaces: characters in, parse results out, configuration writes.
interface xdp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source(output valid, output char_code, input ready);
  modport sink(input valid, input char_code, output ready);
endinterface

interface xdp_result_if;
  logic                                valid;
  logic                                ready;
  logic                                parse_ok;
  logic                                minus_seen;
  logic signed [xdp_pkg::TICKS_W-1:0]  total_ticks;
  modport source(output valid, output parse_ok, output minus_seen, output total_ticks,
                 input ready);
  modport sink(input valid, input parse_ok, input minus_seen, input total_ticks,
               output ready);
endinterface

interface xdp_cfg_if;
  logic valid;
  logic ready;
  logic strict_format;
  modport source(output valid, output strict_format, input ready);
  modport sink(input valid, input strict_format, output ready);
endinterface

[rtl/core/xdp_front.sv]
// Character front end: grammar tracking, digit runs, one record per string.
module xdp_front #(
  parameter int MAX_DIGITS      = xdp_pkg::MAX_DIGITS_DEF,
  parameter int FRACTION_DIGITS = xdp_pkg::FRACTION_DIGITS_DEF,
  parameter int REC_W           = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  xdp_char_if.sink          in_chan,
  xdp_cfg_if.sink           cfg_chan,
  output logic              push_valid,
  input  logic              push_ready,
  output logic [REC_W-1:0]  push_data
);

  localparam int ACC_W     = $clog2(10 ** MAX_DIGITS);
  localparam int DCNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int FRAC_KEEP = (FRACTION_DIGITS < xdp_pkg::TICK_DIGITS) ?
                             FRACTION_DIGITS : xdp_pkg::TICK_DIGITS;
  localparam int FRAC_W    = $clog2(10 ** FRAC_KEEP);
  localparam int FCNT_W    = $clog2(FRAC_KEEP + 1);

  xdp_pkg::phase_t   phase_r, phase_nxt;
  logic              strict_r;
  logic              sign_r, sign_nxt;
  logic              err_r, err_nxt;
  logic [ACC_W-1:0]  dacc_r, dacc_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [FRAC_W-1:0] facc_r, facc_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [ACC_W-1:0]  day_r, day_nxt;
  logic [ACC_W-1:0]  hour_r, hour_nxt;
  logic [ACC_W-1:0]  min_r, min_nxt;
  logic [ACC_W-1:0]  sec_r, sec_nxt;

  logic [7:0]        c;
  logic [3:0]        dval;
  logic              dig;
  logic              take;
  logic              do_int;
  logic              do_frac;
  logic              do_take;
  logic              end_ok;
  logic [ACC_W-1:0]  sec_end;

  assign c    = in_chan.char_code;
  assign dval = c[3:0];
  assign dig  = (c >= xdp_pkg::CH_ZERO) && (c <= xdp_pkg::CH_NINE);
  assign take = in_chan.valid && in_chan.ready;

  assign in_chan.ready  = push_ready;
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    end_ok  = 1'b0;
    sec_end = sec_r;
    case (phase_r)
      xdp_pkg::PH_START: end_ok = !strict_r;
      xdp_pkg::PH_AFTER_P, xdp_pkg::PH_AFTER_D, xdp_pkg::PH_H_WAIT,
      xdp_pkg::PH_M_WAIT, xdp_pkg::PH_S_WAIT, xdp_pkg::PH_DONE,
      xdp_pkg::PH_B_FRAC: end_ok = 1'b1;
      xdp_pkg::PH_B_INT: begin
        end_ok  = 1'b1;
        sec_end = dacc_r;
      end
      default: end_ok = 1'b0;
    endcase
    if (err_r) end_ok = 1'b0;
  end

  assign push_valid = take && (c == xdp_pkg::CH_NUL);
  assign push_data  = {end_ok, end_ok & sign_r, day_r, hour_r, min_r, sec_end,
                       facc_r, fcnt_r};

  always_comb begin
    phase_nxt = phase_r;
    sign_nxt  = sign_r;
    err_nxt   = err_r;
    dacc_nxt  = dacc_r;
    dcnt_nxt  = dcnt_r;
    facc_nxt  = facc_r;
    fcnt_nxt  = fcnt_r;
    day_nxt   = day_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    do_int    = 1'b0;
    do_frac   = 1'b0;
    do_take   = 1'b0;

    if (take && (c != xdp_pkg::CH_NUL) && !err_r) begin
      case (phase_r)
        xdp_pkg::PH_START: begin
          if (c == xdp_pkg::CH_MINUS && !sign_r) sign_nxt = 1'b1;
          else if (c == xdp_pkg::CH_P) phase_nxt = xdp_pkg::PH_AFTER_P;
          else if (!strict_r && dig) begin
            phase_nxt = xdp_pkg::PH_B_INT;
            do_int    = 1'b1;
          end else err_nxt = 1'b1;
        end
        xdp_pkg::PH_AFTER_P: begin
          if (c == xdp_pkg::CH_T) phase_nxt = xdp_pkg::PH_H_WAIT;
          else if (dig) begin
            phase_nxt = xdp_pkg::PH_DAY_INT;
            do_int    = 1'b1;
          end else err_nxt = 1'b1;
        end
        xdp_pkg::PH_DAY_INT: begin
          if (dig) do_int = 1'b1;
          else if (c == xdp_pkg::CH_D) begin
            day_nxt   = dacc_r;
            do_take   = 1'b1;
            phase_nxt = xdp_pkg::PH_AFTER_D;
          end else err_nxt = 1'b1;
        end
        xdp_pkg::PH_AFTER_D: begin
          if (c == xdp_pkg::CH_T) phase_nxt = xdp_pkg::PH_H_WAIT;
          else err_nxt = 1'b1;
        end
        xdp_pkg::PH_H_WAIT: begin
          if (dig) begin
            phase_nxt = xdp_pkg::PH_H_INT;
            do_int    = 1'b1;
          end else err_nxt = 1'b1;
        end
        xdp_pkg::PH_M_WAIT: begin
          if (dig) begin
            phase_nxt = xdp_pkg::PH_M_INT;
            do_int    = 1'b1;
          end else err_nxt = 1'b1;
        end
        xdp_pkg::PH_S_WAIT: begin
          if (dig) begin
            phase_nxt = xdp_pkg::PH_S_INT;
            do_int    = 1'b1;
          end else err_nxt = 1'b1;
        end
        xdp_pkg::PH_H_INT, xdp_pkg::PH_M_INT, xdp_pkg::PH_S_INT: begin
          if (dig) do_int = 1'b1;
          else if (c == xdp_pkg::CH_H && phase_r == xdp_pkg::PH_H_INT) begin
            hour_nxt  = dacc_r;
            do_take   = 1'b1;
            phase_nxt = xdp_pkg::PH_M_WAIT;
          end else if (c == xdp_pkg::CH_M && phase_r != xdp_pkg::PH_S_INT) begin
            min_nxt   = dacc_r;
            do_take   = 1'b1;
            phase_nxt = xdp_pkg::PH_S_WAIT;
          end else if (c == xdp_pkg::CH_S) begin
            sec_nxt   = dacc_r;
            do_take   = 1'b1;
            phase_nxt = xdp_pkg::PH_DONE;
          end else if (c == xdp_pkg::CH_DOT) begin
            sec_nxt   = dacc_r;
            do_take   = 1'b1;
            phase_nxt = xdp_pkg::PH_T_FRAC1;
          end else err_nxt = 1'b1;
        end
        xdp_pkg::PH_T_FRAC1: begin
          if (dig) begin
            do_frac   = 1'b1;
            phase_nxt = xdp_pkg::PH_T_FRAC;
          end else err_nxt = 1'b1;
        end
        xdp_pkg::PH_B_FRAC1: begin
          if (dig) begin
            do_frac   = 1'b1;
            phase_nxt = xdp_pkg::PH_B_FRAC;
          end else err_nxt = 1'b1;
        end
        xdp_pkg::PH_T_FRAC: begin
          if (dig) do_frac = 1'b1;
          else if (c == xdp_pkg::CH_S) phase_nxt = xdp_pkg::PH_DONE;
          else err_nxt = 1'b1;
        end
        xdp_pkg::PH_B_INT: begin
          if (dig) do_int = 1'b1;
          else if (c == xdp_pkg::CH_DOT) begin
            sec_nxt   = dacc_r;
            do_take   = 1'b1;
            phase_nxt = xdp_pkg::PH_B_FRAC1;
          end else err_nxt = 1'b1;
        end
        xdp_pkg::PH_B_FRAC: begin
          if (dig) do_frac = 1'b1;
          else err_nxt = 1'b1;
        end
        default: err_nxt = 1'b1;
      endcase

      if (do_int) begin
        if (dcnt_r < DCNT_W'(MAX_DIGITS)) begin
          dacc_nxt = ACC_W'((ACC_W + 4)'(dacc_r) * (ACC_W + 4)'(10) + (ACC_W + 4)'(dval));
          dcnt_nxt = DCNT_W'(dcnt_r + 1'b1);
        end else err_nxt = 1'b1;
      end
      // digits past the kept ones would be cut off by the tick scaling anyway
      if (do_frac && (fcnt_r < FCNT_W'(FRAC_KEEP))) begin
        facc_nxt = FRAC_W'((FRAC_W + 4)'(facc_r) * (FRAC_W + 4)'(10) + (FRAC_W + 4)'(dval));
        fcnt_nxt = FCNT_W'(fcnt_r + 1'b1);
      end
      if (do_take) begin
        dacc_nxt = '0;
        dcnt_nxt = '0;
      end
    end

    if (push_valid) begin
      phase_nxt = xdp_pkg::PH_START;
      sign_nxt  = 1'b0;
      err_nxt   = 1'b0;
      dacc_nxt  = '0;
      dcnt_nxt  = '0;
      facc_nxt  = '0;
      fcnt_nxt  = '0;
      day_nxt   = '0;
      hour_nxt  = '0;
      min_nxt   = '0;
      sec_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
      phase_r  <= xdp_pkg::PH_START;
      sign_r   <= 1'b0;
      err_r    <= 1'b0;
      dacc_r   <= '0;
      dcnt_r   <= '0;
      facc_r   <= '0;
      fcnt_r   <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      min_r    <= '0;
      sec_r    <= '0;
    end else begin
      if (cfg_chan.valid) strict_r <= cfg_chan.strict_format;
      phase_r <= phase_nxt;
      sign_r  <= sign_nxt;
      err_r   <= err_nxt;
      dacc_r  <= dacc_nxt;
      dcnt_r  <= dcnt_nxt;
      facc_r  <= facc_nxt;
      fcnt_r  <= fcnt_nxt;
      day_r   <= day_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
    end
  end

endmodule

[rtl/core/xdp_queue.sv]
// Short register queue of per-string records between front end and back end.
module xdp_queue #(
  parameter int W     = 8,
  parameter int DEPTH = xdp_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wptr_r + 1'b1);
    if (do_pop)  rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rptr_r + 1'b1);
    if (do_push && !do_pop) cnt_nxt = CNT_W'(cnt_r + 1'b1);
    else if (do_pop && !do_push) cnt_nxt = CNT_W'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

endmodule

[rtl/core/xdp_back.sv]
// Back end: combines the parts of one string into signed microsecond ticks.
module xdp_back #(
  parameter int MAX_DIGITS      = xdp_pkg::MAX_DIGITS_DEF,
  parameter int FRACTION_DIGITS = xdp_pkg::FRACTION_DIGITS_DEF,
  parameter int REC_W           = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  logic [REC_W-1:0] pop_data,
  xdp_result_if.source     out_chan
);

  localparam int ACC_W     = $clog2(10 ** MAX_DIGITS);
  localparam int FRAC_KEEP = (FRACTION_DIGITS < xdp_pkg::TICK_DIGITS) ?
                             FRACTION_DIGITS : xdp_pkg::TICK_DIGITS;
  localparam int FRAC_W    = $clog2(10 ** FRAC_KEEP);
  localparam int FCNT_W    = $clog2(FRAC_KEEP + 1);
  localparam int HW        = ACC_W + 5;
  localparam int PW        = HW + xdp_pkg::MULT_B_W;
  localparam int SUM_W     = PW + 2;
  localparam int TW        = xdp_pkg::TICKS_W;

  xdp_pkg::bk_state_t st_r, st_nxt;
  logic [2:0]         term_r, term_nxt;
  logic               ok_r, ok_nxt;
  logic               neg_r, neg_nxt;
  logic [HW-1:0]      hours_r, hours_nxt;
  logic [ACC_W-1:0]   min_r, min_nxt;
  logic [ACC_W-1:0]   sec_r, sec_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [FCNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic [PW-1:0]      prod_r, prod_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [TW-1:0]      ticks_r, ticks_nxt;

  logic               rec_ok;
  logic               rec_neg;
  logic [ACC_W-1:0]   rec_day;
  logic [ACC_W-1:0]   rec_hour;
  logic [ACC_W-1:0]   rec_min;
  logic [ACC_W-1:0]   rec_sec;
  logic [FRAC_W-1:0]  rec_frac;
  logic [FCNT_W-1:0]  rec_fcnt;
  logic [HW-1:0]      op_a;
  logic [xdp_pkg::MULT_B_W-1:0] op_b;
  logic [TW-1:0]      mag;

  assign {rec_ok, rec_neg, rec_day, rec_hour, rec_min, rec_sec, rec_frac, rec_fcnt} = pop_data;

  assign pop_ready            = (st_r == xdp_pkg::BK_IDLE);
  assign out_chan.valid       = (st_r == xdp_pkg::BK_OUT);
  assign out_chan.parse_ok    = ok_r;
  assign out_chan.minus_seen  = neg_r;
  assign out_chan.total_ticks = ticks_r;

  always_comb begin
    case (term_r)
      3'd0: begin
        op_a = hours_r;
        op_b = xdp_pkg::TICKS_PER_HOUR;
      end
      3'd1: begin
        op_a = HW'(min_r);
        op_b = xdp_pkg::TICKS_PER_MIN;
      end
      3'd2: begin
        op_a = HW'(sec_r);
        op_b = xdp_pkg::TICKS_PER_SEC;
      end
      3'd3: begin
        op_a = HW'(frac_r);
        op_b = xdp_pkg::frac_scale(3'(fcnt_r));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mag = TW'(sum_r);

  always_comb begin
    st_nxt    = st_r;
    term_nxt  = term_r;
    ok_nxt    = ok_r;
    neg_nxt   = neg_r;
    hours_nxt = hours_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    frac_nxt  = frac_r;
    fcnt_nxt  = fcnt_r;
    prod_nxt  = prod_r;
    sum_nxt   = sum_r;
    ticks_nxt = ticks_r;
    case (st_r)
      xdp_pkg::BK_IDLE: begin
        if (pop_valid) begin
          ok_nxt    = rec_ok;
          neg_nxt   = rec_neg;
          hours_nxt = (HW'(rec_day) << 4) + (HW'(rec_day) << 3) + HW'(rec_hour);
          min_nxt   = rec_min;
          sec_nxt   = rec_sec;
          frac_nxt  = rec_frac;
          fcnt_nxt  = rec_fcnt;
          prod_nxt  = '0;
          sum_nxt   = '0;
          term_nxt  = 3'd0;
          st_nxt    = xdp_pkg::BK_MUL;
        end
      end
      xdp_pkg::BK_MUL: begin
        prod_nxt = PW'(op_a) * PW'(op_b);
        sum_nxt  = sum_r + SUM_W'(prod_r);
        term_nxt = term_r + 3'd1;
        if (term_r == 3'd4) st_nxt = xdp_pkg::BK_SIGN;
      end
      xdp_pkg::BK_SIGN: begin
        if (!ok_r) ticks_nxt = '0;
        else if (neg_r) ticks_nxt = -mag;
        else ticks_nxt = mag;
        st_nxt = xdp_pkg::BK_OUT;
      end
      xdp_pkg::BK_OUT: begin
        if (out_chan.ready) st_nxt = xdp_pkg::BK_IDLE;
      end
      default: st_nxt = xdp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= xdp_pkg::BK_IDLE;
      term_r <= 3'd0;
    end else begin
      st_r   <= st_nxt;
      term_r <= term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    neg_r   <= neg_nxt;
    hours_r <= hours_nxt;
    min_r   <= min_nxt;
    sec_r   <= sec_nxt;
    frac_r  <= frac_nxt;
    fcnt_r  <= fcnt_nxt;
    prod_r  <= prod_nxt;
    sum_r   <= sum_nxt;
    ticks_r <= ticks_nxt;
  end

endmodule

[rtl/core/xsd_duration_text_parser.sv]
// Duration text parser top level: front end, record queue and tick combiner.
// Characters of an ISO 8601 / XSD duration string ("-P1DT2H3M4.5S", or bare
// "4.5" seconds when strict_format is 0) are taken one per clock cycle
// while the record queue has room; the zero byte that ends a string makes
// one result with parse_ok, minus_seen and the signed total in microsecond
// ticks. The front end classifies every character in the cycle it is taken
// and, on the zero byte, queues one record in a two-entry queue. The back
// end turns a record into ticks with a single shared multiplier, one term
// per cycle, through pop, five multiply-accumulate steps, sign and output,
// plus any output stall; it takes no new record until its result has left.
// strict_format must be written only while no string is in flight; the
// user must keep to this, as the block itself does not enforce it.
module xsd_duration_text_parser #(
  parameter int MAX_DIGITS      = xdp_pkg::MAX_DIGITS_DEF,
  parameter int FRACTION_DIGITS = xdp_pkg::FRACTION_DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  xdp_char_if.sink      in_chan,
  xdp_result_if.source  out_chan,
  xdp_cfg_if.sink       cfg_chan
);

  localparam int ACC_W     = $clog2(10 ** MAX_DIGITS);
  localparam int FRAC_KEEP = (FRACTION_DIGITS < xdp_pkg::TICK_DIGITS) ?
                             FRACTION_DIGITS : xdp_pkg::TICK_DIGITS;
  localparam int FRAC_W    = $clog2(10 ** FRAC_KEEP);
  localparam int FCNT_W    = $clog2(FRAC_KEEP + 1);
  localparam int REC_W     = 2 + 4 * ACC_W + FRAC_W + FCNT_W;

  logic             push_valid;
  logic             push_ready;
  logic [REC_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [REC_W-1:0] pop_data;

  xdp_front #(
    .MAX_DIGITS      (MAX_DIGITS),
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .REC_W           (REC_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  xdp_queue #(
    .W     (REC_W),
    .DEPTH (xdp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  xdp_back #(
    .MAX_DIGITS      (MAX_DIGITS),
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .REC_W           (REC_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_chan  (out_chan)
  );

endmodule

[dv/xsd_duration_text_parser_checker.sv]
// Checker for the duration parser: predicts each result from the observed requests and compares.
module xsd_duration_text_parser_checker
  import xdp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  xdp_char_if    in_chan,
  xdp_result_if  out_chan,
  xdp_cfg_if     cfg_chan,
  output int     fail_count,
  output int     pending
);

  typedef struct packed {
    logic               parse_ok;
    logic               minus_seen;
    logic [TICKS_W-1:0] total_ticks;
  } duration_t;

  duration_t       expected_durations[$];

  logic            strict_mode;
  phase_t          phase;
  logic            neg;
  logic            err;
  longint unsigned run_val;
  int              run_len;
  longint unsigned frac_val;
  int              frac_len;
  longint unsigned days;
  longint unsigned hours;
  longint unsigned mins;
  longint unsigned secs;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_parse();
    phase    = PH_START;
    neg      = 1'b0;
    err      = 1'b0;
    run_val  = 0;
    run_len  = 0;
    frac_val = 0;
    frac_len = 0;
    days     = 0;
    hours    = 0;
    mins     = 0;
    secs     = 0;
  endtask

  task automatic add_int(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    if (run_len < MAX_DIGITS_DEF) begin
      run_val = run_val * 10 + d;
      run_len++;
    end else begin
      err = 1'b1;
    end
  endtask

  task automatic add_frac(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    if (frac_len < FRACTION_DIGITS_DEF) begin
      frac_val = frac_val * 10 + d;
      frac_len++;
    end
  endtask

  function automatic longint unsigned take_run();
    longint unsigned v;
    v = run_val;
    run_val = 0;
    run_len = 0;
    return v;
  endfunction

  task automatic parse_char(input logic [7:0] c);
    logic dig;
    dig = is_digit(c);
    case (phase)
      PH_START: begin
        if (c == CH_MINUS && !neg) neg = 1'b1;
        else if (c == CH_P) phase = PH_AFTER_P;
        else if (!strict_mode && dig) begin
          phase = PH_B_INT;
          add_int(c);
        end else err = 1'b1;
      end
      PH_AFTER_P: begin
        if (c == CH_T) phase = PH_H_WAIT;
        else if (dig) begin
          phase = PH_DAY_INT;
          add_int(c);
        end else err = 1'b1;
      end
      PH_DAY_INT: begin
        if (dig) add_int(c);
        else if (c == CH_D) begin
          days  = take_run();
          phase = PH_AFTER_D;
        end else err = 1'b1;
      end
      PH_AFTER_D: begin
        if (c == CH_T) phase = PH_H_WAIT;
        else err = 1'b1;
      end
      PH_H_WAIT, PH_M_WAIT, PH_S_WAIT: begin
        if (dig) begin
          phase = phase_t'(phase + 4'd1);
          add_int(c);
        end else err = 1'b1;
      end
      PH_H_INT, PH_M_INT, PH_S_INT: begin
        if (dig) add_int(c);
        else if (c == CH_H && phase == PH_H_INT) begin
          hours = take_run();
          phase = PH_M_WAIT;
        end else if (c == CH_M && phase != PH_S_INT) begin
          mins  = take_run();
          phase = PH_S_WAIT;
        end else if (c == CH_S) begin
          secs  = take_run();
          phase = PH_DONE;
        end else if (c == CH_DOT) begin
          secs  = take_run();
          phase = PH_T_FRAC1;
        end else err = 1'b1;
      end
      PH_T_FRAC1, PH_B_FRAC1: begin
        if (dig) begin
          add_frac(c);
          phase = phase_t'(phase + 4'd1);
        end else err = 1'b1;
      end
      PH_T_FRAC: begin
        if (dig) add_frac(c);
        else if (c == CH_S) phase = PH_DONE;
        else err = 1'b1;
      end
      PH_B_INT: begin
        if (dig) add_int(c);
        else if (c == CH_DOT) begin
          secs  = take_run();
          phase = PH_B_FRAC1;
        end else err = 1'b1;
      end
      PH_B_FRAC: begin
        if (dig) add_frac(c);
        else err = 1'b1;
      end
      default: err = 1'b1;
    endcase
  endtask

  function automatic duration_t finish_duration();
    logic            ok;
    longint unsigned scale;
    longint unsigned total;
    duration_t       r;
    ok = !err;
    if (ok) begin
      case (phase)
        PH_START: ok = !strict_mode;
        PH_AFTER_P, PH_AFTER_D, PH_H_WAIT, PH_M_WAIT, PH_S_WAIT, PH_DONE, PH_B_FRAC: ok = 1'b1;
        PH_B_INT: begin
          secs = take_run();
          ok   = 1'b1;
        end
        default: ok = 1'b0;
      endcase
    end
    r = '0;
    if (ok) begin
      scale = 1;
      repeat (TICK_DIGITS - frac_len) scale = scale * 10;
      total = ((days * 24 + hours) * 3600 + mins * 60 + secs) * 1000000 + frac_val * scale;
      if (neg) total = -total;
      r.parse_ok    = 1'b1;
      r.minus_seen  = neg;
      r.total_ticks = total;
    end
    return r;
  endfunction

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    duration_t want;
    if (!rst_n) begin
      clear_parse();
      strict_mode = 1'b0;
      expected_durations.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_durations.size() == 0) begin
          $display("%0t: result with no request pending, actual ok %0d neg %0d ticks %0d",
                   $time, out_chan.parse_ok, out_chan.minus_seen, out_chan.total_ticks);
          fail_count++;
        end else begin
          want = expected_durations.pop_front();
          report_field("parse_ok", want.parse_ok, out_chan.parse_ok);
          report_field("minus_seen", want.minus_seen, out_chan.minus_seen);
          report_field("total_ticks", want.total_ticks, out_chan.total_ticks);
        end
      end
      if (cfg_chan.valid && cfg_chan.ready) strict_mode = cfg_chan.strict_format;
      if (in_chan.valid && in_chan.ready) begin
        if (in_chan.char_code == CH_NUL) begin
          expected_durations.push_back(finish_duration());
          clear_parse();
        end else if (!err) begin
          parse_char(in_chan.char_code);
        end
      end
    end
    pending = expected_durations.size();
  end

endmodule

[dv/xsd_duration_text_parser_tb.sv]
// Testbench top for the duration parser: clock, reset, string stimulus, receiver and verdict.
module xsd_duration_text_parser_tb;
  import xdp_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_CHARS    = 165;

  localparam logic [7:0] SYMBOLS [9] = '{CH_MINUS, CH_DOT, CH_D, CH_H, CH_M, CH_P, CH_S, CH_T,
                                         CH_ZERO};

  typedef enum logic [1:0] {
    MUT_REPLACE,
    MUT_DROP,
    MUT_INSERT,
    MUT_CUT
  } mutation_t;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   results_pending;
  int   hold_reqs = 0;
  int   chars_sent = 0;
  int   idle_cycles = 0;

  logic [7:0] text_q[$];

  xdp_char_if   in_if();
  xdp_result_if out_if();
  xdp_cfg_if    cfg_if();

  xsd_duration_text_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  xsd_duration_text_parser_checker duration_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_chan   (cfg_if),
    .fail_count (fail_count),
    .pending    (results_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 6);
    return $urandom_range(7, 8);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_text_q(input logic calm);
    foreach (text_q[i]) send_char(text_q[i], calm);
    send_char(CH_NUL, calm);
    chars_sent += text_q.size() + 1;
  endtask

  task automatic send_string(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text_q(1'b0);
  endtask

  task automatic add_digits(input int n);
    repeat (n) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_field(input logic [7:0] designator);
    add_digits(pick_run_len());
    text_q.push_back(designator);
  endtask

  task automatic build_xsd();
    text_q.delete();
    if ($urandom_range(0, 3) == 0) text_q.push_back(CH_MINUS);
    text_q.push_back(CH_P);
    if ($urandom_range(0, 1)) add_field(CH_D);
    if ($urandom_range(0, 3) != 0) begin
      text_q.push_back(CH_T);
      if ($urandom_range(0, 1)) add_field(CH_H);
      if ($urandom_range(0, 1)) add_field(CH_M);
      if ($urandom_range(0, 1)) begin
        add_digits(pick_run_len());
        if ($urandom_range(0, 1)) begin
          text_q.push_back(CH_DOT);
          add_digits($urandom_range(1, 8));
        end
        text_q.push_back(CH_S);
      end
    end
  endtask

  task automatic build_bare();
    text_q.delete();
    if ($urandom_range(0, 3) == 0) text_q.push_back(CH_MINUS);
    add_digits(pick_run_len());
    if ($urandom_range(0, 1)) begin
      text_q.push_back(CH_DOT);
      add_digits($urandom_range(0, 8));
    end
  endtask

  task automatic mutate_text();
    mutation_t  op;
    int         pos;
    logic [7:0] sym;
    op  = mutation_t'($urandom_range(0, 3));
    sym = $urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : SYMBOLS[$urandom_range(0, 8)];
    if (text_q.size() == 0) begin
      text_q.push_back(sym);
    end else begin
      pos = $urandom_range(0, text_q.size() - 1);
      case (op)
        MUT_REPLACE: text_q[pos] = sym;
        MUT_DROP:    text_q.delete(pos);
        MUT_INSERT:  text_q.insert(pos, sym);
        default: begin
          while (text_q.size() > pos) void'(text_q.pop_back());
        end
      endcase
    end
  endtask

  task automatic build_random();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      build_xsd();
    end else if (kind < 65) begin
      build_bare();
    end else if (kind < 90) begin
      if ($urandom_range(0, 1)) build_xsd();
      else build_bare();
      mutate_text();
    end else begin
      text_q.delete();
      repeat ($urandom_range(0, 8)) text_q.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic write_strict(input logic value);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.strict_format <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(input int quota, input logic with_hold);
    int   start;
    int   strings;
    logic calm;
    start   = chars_sent;
    strings = 0;
    while (chars_sent - start < quota) begin
      if (with_hold && strings == 12) hold_reqs++;
      calm = (with_hold && strings >= 12 && strings < 40) || ($urandom_range(0, 5) == 0);
      build_random();
      send_text_q(calm);
      strings++;
    end
  endtask

  // receiver: random stalls, ready streaks, and a long hold-off on request
  initial begin
    int stall_len;
    int ready_len;
    int holds_done;
    out_if.ready = 1'b0;
    holds_done   = 0;
    @(negedge clk);
    forever begin
      stall_len = pick_gap();
      if (holds_done != hold_reqs) begin
        holds_done++;
        stall_len += HOLD_CYCLES;
      end
      if (stall_len > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall_len) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      ready_len = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 60) : 1;
      repeat (ready_len) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.char_code      = CH_NUL;
    cfg_if.valid         = 1'b0;
    cfg_if.strict_format = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // bare seconds allowed (reset value)
    send_string("");
    send_string("-");
    send_string("P");
    send_string("PT");
    send_string("P1DT");
    send_string("-P999999DT999999H999999M999999.999999S");
    send_string("PT1M1H");
    send_string("PT1S1");
    send_string("P1D2");
    send_string("P12H");
    send_string("PT1.S");
    send_string("PT1.1234567S");
    send_string("1234567");
    send_string("-0.000001");
    send_string("3.");
    send_string("--1");
    send_string("P1DX1");
    send_string("PT5H6S");
    send_string("p1d");
    text_q = '{8'hFF, 8'h80, 8'h7F};
    send_text_q(1'b0);

    write_strict(1'b1);
    send_string("");
    send_string("-");
    send_string("5");
    send_string("-P1D");
    send_string("PT0.5S");
    random_phase(PHASE_CHARS, 1'b0);

    write_strict(1'b0);
    random_phase(PHASE_CHARS, 1'b1);

    write_strict(1'b1);
    random_phase(PHASE_CHARS, 1'b0);

    write_strict(1'b0);
    random_phase(PHASE_CHARS, 1'b0);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[xsd_duration_text_parser.f]
rtl/core/xdp_pkg.sv
rtl/core/xdp_if.sv
rtl/core/xdp_front.sv
rtl/core/xdp_queue.sv
rtl/core/xdp_back.sv
rtl/core/xsd_duration_text_parser.sv
dv/xsd_duration_text_parser_checker.sv
dv/xsd_duration_text_parser_tb.sv
